// ===== src/bpe_pkg.sv =====
// Shared constants, types and state encodings for the bivariate polynomial evaluator.
// Depends on nothing; every other file but the self-contained bpe_ram refers to it by scoped names.
`default_nettype none

package bpe_pkg;

    // Degree limit and derived table sizes
    localparam int MAX_DEGREE = 10;
    localparam int NTERMS     = (MAX_DEGREE + 1) * (MAX_DEGREE + 2) / 2;
    localparam int DEG_W      = $clog2(MAX_DEGREE + 1);
    localparam int TIDX_W     = $clog2(NTERMS);
    localparam int PWR_DEPTH  = 2 * (MAX_DEGREE + 1);
    localparam int PA_W       = $clog2(PWR_DEPTH);
    localparam int Y_BASE     = MAX_DEGREE + 1;

    // Port field widths
    localparam int IDX_W  = 7;
    localparam int COEF_W = 32;
    localparam int PT_W   = 16;
    localparam int RES_W  = 48;
    localparam int CFG_W  = 4;

    // Fixed point formats
    localparam int IN_FRAC  = 14;
    localparam int POW_FRAC = 28;
    localparam int POW_W    = 40;
    localparam int HALF_W   = POW_W / 2;
    localparam int MUL_W    = 2 * POW_W;
    localparam int TERM_W   = COEF_W + POW_W - POW_FRAC;
    localparam int ACC_RAW  = TERM_W + $clog2(NTERMS);
    localparam int ACC_W    = (ACC_RAW > RES_W) ? ACC_RAW : RES_W + 1;

    localparam logic signed [POW_W-1:0] POW_ONE =
        {{(POW_W - POW_FRAC - 1){1'b0}}, 1'b1, {POW_FRAC{1'b0}}};
    localparam logic signed [POW_W-1:0] POW_MAX = {1'b0, {(POW_W - 1){1'b1}}};
    localparam logic signed [POW_W-1:0] POW_MIN = {1'b1, {(POW_W - 1){1'b0}}};
    localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W - 1){1'b1}}};
    localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W - 1){1'b0}}};

    // Item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PINIT_X,
        ST_PINIT_Y,
        ST_PSTART,
        ST_PWAIT,
        ST_TRD_X,
        ST_TRD_Y,
        ST_TMONO,
        ST_TMONO_W,
        ST_TTERM,
        ST_TTERM_W,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_LO,
        MUL_HI,
        MUL_FIN
    } t_mul_phase;

    typedef struct packed {
        logic start;
        logic frac_hi;   // 1: shift by POW_FRAC, 0: shift by IN_FRAC
    } t_mul_ctl;

endpackage

`default_nettype wire

// ===== src/bpe_in_if.sv =====
// Input channel of the evaluator: valid/ready handshake plus one input item.
// Depends on bpe_pkg for field widths.
`default_nettype none

interface bpe_in_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic [bpe_pkg::IDX_W-1:0]           coef_index;
    logic signed [bpe_pkg::COEF_W-1:0]   coef_value;
    logic signed [bpe_pkg::PT_W-1:0]     x_value;
    logic signed [bpe_pkg::PT_W-1:0]     y_value;

    modport source (
        output valid, kind, coef_index, coef_value, x_value, y_value,
        input  ready
    );
    modport sink (
        input  valid, kind, coef_index, coef_value, x_value, y_value,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/bpe_out_if.sv =====
// Output channel of the evaluator: valid/ready handshake plus one result item.
// Depends on bpe_pkg for field widths.
`default_nettype none

interface bpe_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [bpe_pkg::RES_W-1:0]   result;
    logic                               overflow;

    modport source (
        output valid, result, overflow,
        input  ready
    );
    modport sink (
        input  valid, result, overflow,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/bpe_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Self contained; no reset on the array.
`default_nettype none

module bpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/bpe_coef.sv =====
// Coefficient table: RAM plus per-entry valid bits so unwritten entries read zero.
// Depends on bpe_pkg and bpe_ram.
`default_nettype none

module bpe_coef (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_we,
    input  logic [bpe_pkg::TIDX_W-1:0]          i_waddr,
    input  logic signed [bpe_pkg::COEF_W-1:0]   i_wdata,
    input  logic                                i_re,
    input  logic [bpe_pkg::TIDX_W-1:0]          i_raddr,
    output logic signed [bpe_pkg::COEF_W-1:0]   o_rdata
);

    logic [bpe_pkg::NTERMS-1:0]   r_valid;
    logic                         r_rd_valid;
    logic [bpe_pkg::COEF_W-1:0]   w_ram_q;

    bpe_ram #(
        .WIDTH (bpe_pkg::COEF_W),
        .DEPTH (bpe_pkg::NTERMS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_re    (i_re),
        .i_raddr (i_raddr),
        .o_rdata (w_ram_q)
    );

    // valid bits stand in for clearing the RAM after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_valid <= r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_rd_valid ? w_ram_q : '0;

endmodule

`default_nettype wire

// ===== src/bpe_mul.sv =====
// Shared 40x40 signed multiplier: two 40x21 partial products in the MUL_LO and MUL_HI phases,
// then floor shift and 40-bit clamp on o_sat (o_wide is not clamped). Depends on bpe_pkg.
`default_nettype none

module bpe_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bpe_pkg::t_mul_ctl                   i_ctl,
    input  logic signed [bpe_pkg::POW_W-1:0]    i_a,
    input  logic signed [bpe_pkg::POW_W-1:0]    i_b,
    output logic                                o_done,
    output logic signed [bpe_pkg::POW_W-1:0]    o_sat,
    output logic signed [bpe_pkg::TERM_W-1:0]   o_wide
);

    bpe_pkg::t_mul_phase r_phase, n_phase;

    logic signed [bpe_pkg::POW_W-1:0]          r_a, r_b;
    logic                                      r_frac_hi;
    logic signed [bpe_pkg::MUL_W-1:0]          r_p;
    logic                                      r_done;
    logic signed [bpe_pkg::POW_W-1:0]          r_sat;
    logic signed [bpe_pkg::TERM_W-1:0]         r_wide;

    logic signed [bpe_pkg::HALF_W:0]                  w_bsel;
    logic signed [bpe_pkg::POW_W+bpe_pkg::HALF_W:0]   w_prod;
    logic signed [bpe_pkg::MUL_W-1:0]                 w_shifted;
    logic [bpe_pkg::MUL_W-bpe_pkg::POW_W:0]           w_top;
    logic                                             w_fits;

    // low half of b is unsigned, high half carries the sign
    always_comb begin
        if (r_phase == bpe_pkg::MUL_HI) begin
            w_bsel = {r_b[bpe_pkg::POW_W-1], r_b[bpe_pkg::POW_W-1:bpe_pkg::HALF_W]};
        end else begin
            w_bsel = {1'b0, r_b[bpe_pkg::HALF_W-1:0]};
        end
    end

    assign w_prod    = r_a * w_bsel;
    assign w_shifted = r_frac_hi ? (r_p >>> bpe_pkg::POW_FRAC) : (r_p >>> bpe_pkg::IN_FRAC);
    assign w_top     = w_shifted[bpe_pkg::MUL_W-1:bpe_pkg::POW_W-1];
    assign w_fits    = (&w_top) | ~(|w_top);

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            bpe_pkg::MUL_IDLE: begin
                if (i_ctl.start) begin
                    n_phase = bpe_pkg::MUL_LO;
                end
            end
            bpe_pkg::MUL_LO:  n_phase = bpe_pkg::MUL_HI;
            bpe_pkg::MUL_HI:  n_phase = bpe_pkg::MUL_FIN;
            bpe_pkg::MUL_FIN: n_phase = bpe_pkg::MUL_IDLE;
            default:          n_phase = bpe_pkg::MUL_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bpe_pkg::MUL_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == bpe_pkg::MUL_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start && r_phase == bpe_pkg::MUL_IDLE) begin
            r_a       <= i_a;
            r_b       <= i_b;
            r_frac_hi <= i_ctl.frac_hi;
        end
        case (r_phase)
            bpe_pkg::MUL_LO: r_p <= bpe_pkg::MUL_W'(w_prod);
            bpe_pkg::MUL_HI: r_p <= r_p + (bpe_pkg::MUL_W'(w_prod) <<< bpe_pkg::HALF_W);
            bpe_pkg::MUL_FIN: begin
                r_sat  <= w_fits ? w_shifted[bpe_pkg::POW_W-1:0]
                                 : (w_shifted[bpe_pkg::MUL_W-1] ? bpe_pkg::POW_MIN
                                                                : bpe_pkg::POW_MAX);
                r_wide <= w_shifted[bpe_pkg::TERM_W-1:0];
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_sat  = r_sat;
    assign o_wide = r_wide;

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> (r_phase == bpe_pkg::MUL_IDLE))
        else $error("multiplier started while busy");

    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.start && r_phase == bpe_pkg::MUL_IDLE) |-> ##4 o_done)
        else $error("multiplier result not ready four cycles after start");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("multiplier done held longer than one cycle");

endmodule

`default_nettype wire

// ===== src/bivariate_polynomial_evaluator.sv =====
// Top level of the bivariate polynomial evaluator: sequencer, power RAM, accumulator.
// Depends on bpe_pkg, bpe_in_if, bpe_out_if, bpe_ram, bpe_coef and bpe_mul.
//
// Usage:
//  - i_in carries items. kind = load writes coef_value (Q16.16) into coefficient
//    entry coef_index (entries past the table are dropped) and gives no result.
//    kind = eval evaluates the polynomial at (x_value, y_value),
//    both Q1.14, and gives one result item on o_out: result (Q32.16, saturated)
//    and overflow (set when the sum was clamped).
//  - i_cfg_we / i_cfg_wdata write the degree register (values above 10 act as 10).
//  - An evaluation, d = degree, N = (d+1)(d+2)/2 terms, runs on the one shared
//    multiplier: first one multiply per power step (2*d steps) fills the power
//    RAM, then for each of the N terms two power RAM reads plus two multiplies
//    add the term into the sum.
//  - One item is worked at a time; i_in.ready is high only while the sequencer is idle,
//    so no new item is taken while an evaluation is under way.
//  - A finished result sits in an output register, so the next item is taken while
//    it waits; if the receiver stalls and a second result is done, the sequencer
//    holds that result until the register frees up.
//  - Reset (synchronous, active low) sets degree to 0, marks every coefficient as
//    zero through valid bits (no clearing pass) and empties the output register.
`default_nettype none

module bivariate_polynomial_evaluator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bpe_in_if.sink                      i_in,
    bpe_out_if.source                   o_out,
    input  logic                        i_cfg_we,
    input  logic [bpe_pkg::CFG_W-1:0]   i_cfg_wdata
);

    bpe_pkg::t_state r_state, n_state;

    logic [bpe_pkg::CFG_W-1:0]              r_degree;
    logic [bpe_pkg::DEG_W-1:0]              r_deg, n_deg;
    logic signed [bpe_pkg::PT_W-1:0]        r_x, n_x, r_y, n_y;
    logic signed [bpe_pkg::POW_W-1:0]       r_xpow, n_xpow, r_ypow, n_ypow;
    logic                                   r_ysel, n_ysel;
    logic [bpe_pkg::DEG_W-1:0]              r_pd, n_pd;
    logic [bpe_pkg::DEG_W-1:0]              r_d, n_d, r_k, n_k;
    logic [bpe_pkg::TIDX_W-1:0]             r_t, n_t;
    logic signed [bpe_pkg::POW_W-1:0]       r_opa, n_opa;
    logic signed [bpe_pkg::ACC_W-1:0]       r_acc, n_acc;
    logic                                   r_out_valid, n_out_valid;
    logic signed [bpe_pkg::RES_W-1:0]       r_result, n_result;
    logic                                   r_overflow, n_overflow;

    logic                                   w_in_ready;
    logic                                   w_out_ready;
    logic [bpe_pkg::DEG_W-1:0]              w_deg_eff;
    logic                                   w_idx_ok;

    bpe_pkg::t_mul_ctl                      w_mul_ctl;
    logic signed [bpe_pkg::POW_W-1:0]       w_mul_a, w_mul_b;
    logic                                   w_mul_done;
    logic signed [bpe_pkg::POW_W-1:0]       w_mul_sat;
    logic signed [bpe_pkg::TERM_W-1:0]      w_mul_wide;

    logic                                   w_pwr_we, w_pwr_re;
    logic [bpe_pkg::PA_W-1:0]               w_pwr_waddr, w_pwr_raddr;
    logic signed [bpe_pkg::POW_W-1:0]       w_pwr_wdata, w_pwr_q;

    logic                                   w_coef_we, w_coef_re;
    logic signed [bpe_pkg::COEF_W-1:0]      w_coef_q;

    logic [bpe_pkg::ACC_W-bpe_pkg::RES_W:0] w_acc_top;
    logic                                   w_acc_fits;
    logic signed [bpe_pkg::RES_W-1:0]       w_res_sat;

    // Power table: x^i at entry i, y^i at entry Y_BASE + i, all Q12.28
    bpe_ram #(
        .WIDTH (bpe_pkg::POW_W),
        .DEPTH (bpe_pkg::PWR_DEPTH)
    ) u_pwr_ram (
        .i_clk   (i_clk),
        .i_we    (w_pwr_we),
        .i_waddr (w_pwr_waddr),
        .i_wdata (w_pwr_wdata),
        .i_re    (w_pwr_re),
        .i_raddr (w_pwr_raddr),
        .o_rdata (w_pwr_q)
    );

    // Coefficient table; loads write it only while idle, the term walk only reads it
    bpe_coef u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_coef_we),
        .i_waddr (bpe_pkg::TIDX_W'(i_in.coef_index)),
        .i_wdata (i_in.coef_value),
        .i_re    (w_coef_re),
        .i_raddr (r_t),
        .o_rdata (w_coef_q)
    );

    bpe_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mul_ctl),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_sat   (w_mul_sat),
        .o_wide  (w_mul_wide)
    );

    assign w_out_ready = o_out.ready;
    assign w_deg_eff   = (r_degree > bpe_pkg::CFG_W'(bpe_pkg::MAX_DEGREE))
                         ? bpe_pkg::DEG_W'(bpe_pkg::MAX_DEGREE)
                         : bpe_pkg::DEG_W'(r_degree);
    assign w_idx_ok    = ({{(32 - bpe_pkg::IDX_W){1'b0}}, i_in.coef_index}
                          < 32'(bpe_pkg::NTERMS));

    // Final clamp of the exact sum to 48 bits
    assign w_acc_top  = r_acc[bpe_pkg::ACC_W-1:bpe_pkg::RES_W-1];
    assign w_acc_fits = (&w_acc_top) | ~(|w_acc_top);
    assign w_res_sat  = w_acc_fits ? r_acc[bpe_pkg::RES_W-1:0]
                                   : (r_acc[bpe_pkg::ACC_W-1] ? bpe_pkg::RES_MIN
                                                              : bpe_pkg::RES_MAX);

    always_comb begin
        n_state     = r_state;
        n_deg       = r_deg;
        n_x         = r_x;
        n_y         = r_y;
        n_xpow      = r_xpow;
        n_ypow      = r_ypow;
        n_ysel      = r_ysel;
        n_pd        = r_pd;
        n_d         = r_d;
        n_k         = r_k;
        n_t         = r_t;
        n_opa       = r_opa;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        n_result    = r_result;
        n_overflow  = r_overflow;

        w_in_ready  = 1'b0;
        w_mul_ctl   = '0;
        w_mul_a     = r_opa;
        w_mul_b     = w_pwr_q;
        w_pwr_we    = 1'b0;
        w_pwr_waddr = '0;
        w_pwr_wdata = w_mul_sat;
        w_pwr_re    = 1'b0;
        w_pwr_raddr = '0;
        w_coef_we   = 1'b0;
        w_coef_re   = 1'b0;

        if (r_out_valid && w_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            bpe_pkg::ST_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in.valid) begin
                    if (i_in.kind == bpe_pkg::KIND_EVAL) begin
                        n_x     = i_in.x_value;
                        n_y     = i_in.y_value;
                        n_deg   = w_deg_eff;
                        n_state = bpe_pkg::ST_PINIT_X;
                    end else begin
                        w_coef_we = w_idx_ok;
                    end
                end
            end
            bpe_pkg::ST_PINIT_X: begin
                w_pwr_we    = 1'b1;
                w_pwr_waddr = '0;
                w_pwr_wdata = bpe_pkg::POW_ONE;
                n_xpow      = bpe_pkg::POW_ONE;
                n_d         = '0;
                n_k         = '0;
                n_t         = '0;
                n_acc       = '0;
                n_state     = bpe_pkg::ST_PINIT_Y;
            end
            bpe_pkg::ST_PINIT_Y: begin
                w_pwr_we    = 1'b1;
                w_pwr_waddr = bpe_pkg::PA_W'(bpe_pkg::Y_BASE);
                w_pwr_wdata = bpe_pkg::POW_ONE;
                n_ypow      = bpe_pkg::POW_ONE;
                n_pd        = bpe_pkg::DEG_W'(1);
                n_ysel      = 1'b0;
                n_state     = (r_deg == '0) ? bpe_pkg::ST_TRD_X : bpe_pkg::ST_PSTART;
            end
            bpe_pkg::ST_PSTART: begin
                // next power = previous power * coordinate, Q12.28 * Q1.14 >> 14
                w_mul_ctl.start   = 1'b1;
                w_mul_ctl.frac_hi = 1'b0;
                w_mul_a = r_ysel ? r_ypow : r_xpow;
                w_mul_b = r_ysel ? bpe_pkg::POW_W'(r_y) : bpe_pkg::POW_W'(r_x);
                n_state = bpe_pkg::ST_PWAIT;
            end
            bpe_pkg::ST_PWAIT: begin
                if (w_mul_done) begin
                    w_pwr_we = 1'b1;
                    if (r_ysel) begin
                        w_pwr_waddr = bpe_pkg::PA_W'(bpe_pkg::Y_BASE) + bpe_pkg::PA_W'(r_pd);
                        n_ypow      = w_mul_sat;
                        n_ysel      = 1'b0;
                        if (r_pd == r_deg) begin
                            n_state = bpe_pkg::ST_TRD_X;
                        end else begin
                            n_pd    = r_pd + bpe_pkg::DEG_W'(1);
                            n_state = bpe_pkg::ST_PSTART;
                        end
                    end else begin
                        w_pwr_waddr = bpe_pkg::PA_W'(r_pd);
                        n_xpow      = w_mul_sat;
                        n_ysel      = 1'b1;
                        n_state     = bpe_pkg::ST_PSTART;
                    end
                end
            end
            bpe_pkg::ST_TRD_X: begin
                // term x^(d-k) * y^k with coefficient t
                w_pwr_re    = 1'b1;
                w_pwr_raddr = bpe_pkg::PA_W'(r_d - r_k);
                w_coef_re   = 1'b1;
                n_state     = bpe_pkg::ST_TRD_Y;
            end
            bpe_pkg::ST_TRD_Y: begin
                n_opa       = w_pwr_q;
                w_pwr_re    = 1'b1;
                w_pwr_raddr = bpe_pkg::PA_W'(bpe_pkg::Y_BASE) + bpe_pkg::PA_W'(r_k);
                n_state     = bpe_pkg::ST_TMONO;
            end
            bpe_pkg::ST_TMONO: begin
                w_mul_ctl.start   = 1'b1;
                w_mul_ctl.frac_hi = 1'b1;
                w_mul_a = r_opa;
                w_mul_b = w_pwr_q;
                n_state = bpe_pkg::ST_TMONO_W;
            end
            bpe_pkg::ST_TMONO_W: begin
                if (w_mul_done) begin
                    n_state = bpe_pkg::ST_TTERM;
                end
            end
            bpe_pkg::ST_TTERM: begin
                // Q16.16 * Q12.28 >> 28 gives the term in Q.16
                w_mul_ctl.start   = 1'b1;
                w_mul_ctl.frac_hi = 1'b1;
                w_mul_a = w_mul_sat;
                w_mul_b = bpe_pkg::POW_W'(w_coef_q);
                n_state = bpe_pkg::ST_TTERM_W;
            end
            bpe_pkg::ST_TTERM_W: begin
                if (w_mul_done) begin
                    n_acc = r_acc + bpe_pkg::ACC_W'(w_mul_wide);
                    n_t   = r_t + bpe_pkg::TIDX_W'(1);
                    if (r_k == r_d) begin
                        if (r_d == r_deg) begin
                            n_state = bpe_pkg::ST_DONE;
                        end else begin
                            n_d     = r_d + bpe_pkg::DEG_W'(1);
                            n_k     = '0;
                            n_state = bpe_pkg::ST_TRD_X;
                        end
                    end else begin
                        n_k     = r_k + bpe_pkg::DEG_W'(1);
                        n_state = bpe_pkg::ST_TRD_X;
                    end
                end
            end
            bpe_pkg::ST_DONE: begin
                // wait here only while the output register still holds a result
                if (!r_out_valid || w_out_ready) begin
                    n_out_valid = 1'b1;
                    n_result    = w_res_sat;
                    n_overflow  = ~w_acc_fits;
                    n_state     = bpe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bpe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bpe_pkg::ST_IDLE;
            r_degree    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_degree <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_deg      <= n_deg;
        r_x        <= n_x;
        r_y        <= n_y;
        r_xpow     <= n_xpow;
        r_ypow     <= n_ypow;
        r_ysel     <= n_ysel;
        r_pd       <= n_pd;
        r_d        <= n_d;
        r_k        <= n_k;
        r_t        <= n_t;
        r_opa      <= n_opa;
        r_acc      <= n_acc;
        r_result   <= n_result;
        r_overflow <= n_overflow;
    end

    assign i_in.ready     = w_in_ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.result   = r_result;
    assign o_out.overflow = r_overflow;

    a_term_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bpe_pkg::ST_TRD_X) |-> ((r_k <= r_d) && (r_d <= r_deg)))
        else $error("term walk left the triangle of monomials");

    a_coef_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bpe_pkg::ST_TRD_X) |-> (r_t < bpe_pkg::TIDX_W'(bpe_pkg::NTERMS)))
        else $error("coefficient index past the table");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bpe_pkg::ST_DONE && r_out_valid && !o_out.ready)
        |=> (r_state == bpe_pkg::ST_DONE))
        else $error("result dropped while output register was full");

endmodule

`default_nettype wire
